// File: sv/bss_pkg.sv
// shared types, widths and codes for the block signal statistics design
// no dependencies; imported by bss_unit, block_signal_statistics and bss_checker
package bss_pkg;

    // default parameter values
    localparam int MAX_COUNT_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // datapath width of the shared arithmetic unit
    localparam int DP_W  = 64;
    localparam int ITR_W = $clog2(DP_W + 1);

    // fixed result field widths
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 40;
    localparam int STD_W    = 24;
    localparam int ENERGY_W = 43;
    localparam int POWER_W  = 39;
    localparam int RMS_W    = 24;
    localparam int STATUS_W = 2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SINGLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP   = 2'd2;

    // operations of the shared unit
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2,
        OP_SUB  = 2'd3
    } op_kind_t;

    // command from the sequencer to the shared unit
    typedef struct packed {
        logic     start;
        op_kind_t kind;
    } unit_cmd_t;

endpackage

// File: sv/bss_unit.sv
// iterative shared arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root and subtract, all on one 64-bit adder
// depends on bss_pkg
module bss_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bss_pkg::unit_cmd_t      cmd,
    input  logic [bss_pkg::DP_W-1:0] opnd_a,
    input  logic [bss_pkg::DP_W-1:0] opnd_b,
    output logic                    done,
    output logic [bss_pkg::DP_W-1:0] result,
    output logic [bss_pkg::DP_W-1:0] remainder
);
    import bss_pkg::*;

    logic [DP_W-1:0]  acc_reg, acc_next;
    logic [DP_W-1:0]  x_reg, x_next;
    logic [DP_W-1:0]  y_reg, y_next;
    logic [ITR_W-1:0] itr_reg, itr_next;
    op_kind_t         kind_reg, kind_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DP_W-1:0] add_x, add_y;
    logic            add_sub;
    logic [DP_W:0]   add_sum;
    logic            carry;
    logic [DP_W-1:0] div_t, sqrt_t, sqrt_trial;

    // shifted partial remainders for divide and root
    assign div_t      = {acc_reg[DP_W-2:0], x_reg[DP_W-1]};
    assign sqrt_t     = {acc_reg[DP_W-3:0], x_reg[DP_W-1:DP_W-2]};
    assign sqrt_trial = {y_reg[DP_W-3:0], 2'b01};

    // adder input selection
    always_comb begin
        add_sub = 1'b1;
        add_x   = acc_reg;
        add_y   = y_reg;
        unique case (kind_reg)
            OP_MUL: begin
                add_sub = 1'b0;
                add_y   = x_reg;
            end
            OP_DIV: begin
                add_x = div_t;
            end
            OP_SQRT: begin
                add_x = sqrt_t;
                add_y = sqrt_trial;
            end
            OP_SUB: begin
                add_x = acc_reg;
            end
            default: begin
                add_x = acc_reg;
            end
        endcase
    end

    // the one shared adder / subtractor
    assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + {{DP_W{1'b0}}, add_sub};
    assign carry   = add_sum[DP_W];

    // load and step
    always_comb begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        itr_next  = itr_reg;
        kind_next = kind_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            kind_next = cmd.kind;
            busy_next = 1'b1;
            acc_next  = '0;
            x_next    = opnd_a;
            y_next    = opnd_b;
            itr_next  = ITR_W'(DP_W);
            unique case (cmd.kind)
                OP_MUL:  itr_next = ITR_W'(DP_W);
                OP_DIV:  itr_next = ITR_W'(DP_W);
                OP_SQRT: begin
                    y_next   = '0;
                    itr_next = ITR_W'(DP_W / 2);
                end
                OP_SUB: begin
                    acc_next = opnd_a;
                    itr_next = ITR_W'(1);
                end
                default: itr_next = ITR_W'(1);
            endcase
        end else if (busy_reg) begin
            unique case (kind_reg)
                OP_MUL: begin
                    if (y_reg[0]) begin
                        acc_next = add_sum[DP_W-1:0];
                    end
                    x_next = {x_reg[DP_W-2:0], 1'b0};
                    y_next = {1'b0, y_reg[DP_W-1:1]};
                end
                OP_DIV: begin
                    acc_next = carry ? add_sum[DP_W-1:0] : div_t;
                    x_next   = {x_reg[DP_W-2:0], carry};
                end
                OP_SQRT: begin
                    acc_next = carry ? add_sum[DP_W-1:0] : sqrt_t;
                    y_next   = {y_reg[DP_W-2:0], carry};
                    x_next   = {x_reg[DP_W-3:0], 2'b00};
                end
                OP_SUB: begin
                    acc_next = add_sum[DP_W-1:0];
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            itr_next = itr_reg - ITR_W'(1);
            if (itr_reg == ITR_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            kind_reg <= OP_MUL;
            itr_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            kind_reg <= kind_next;
            itr_reg  <= itr_next;
        end
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    // result selection
    always_comb begin
        unique case (kind_reg)
            OP_MUL:  result = acc_reg;
            OP_DIV:  result = x_reg;
            OP_SQRT: result = y_reg;
            OP_SUB:  result = acc_reg;
            default: result = acc_reg;
        endcase
    end

    assign remainder = acc_reg;
    assign done      = done_reg;

endmodule

// File: sv/block_signal_statistics.sv
// Block statistics over signed samples: a sample is taken in every cycle in which s_valid
// and s_ready are both high and adds to count, sum, sum of squares, minimum and maximum in
// that cycle. The sample flagged last closes the block; s_ready then stays low while one
// shared 64-bit adder works through three shift-add multiplies, one subtract, three
// restoring divides and two square roots, and while the result is handed to the output
// register, which waits further while the previous result word has not yet been taken.
// The result word then sits in the output register, so the next block may start while it
// waits to be taken. Samples beyond MAX_COUNT in a block are dropped and flagged.
// depends on bss_pkg and bss_unit
module block_signal_statistics #(
    parameter int MAX_COUNT   = bss_pkg::MAX_COUNT_DEF,
    parameter int SAMPLE_BITS = bss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [$clog2(MAX_COUNT+1)-1:0]       m_sample_total,
    output logic signed [bss_pkg::MEAN_W-1:0]    m_mean_q8,
    output logic [bss_pkg::VAR_W-1:0]            m_variance_q8,
    output logic [bss_pkg::STD_W-1:0]            m_std_q8,
    output logic [bss_pkg::ENERGY_W-1:0]         m_energy,
    output logic [bss_pkg::POWER_W-1:0]          m_power_q8,
    output logic [bss_pkg::RMS_W-1:0]            m_rms_q8,
    output logic signed [SAMPLE_BITS-1:0]        m_minimum,
    output logic signed [SAMPLE_BITS-1:0]        m_maximum,
    output logic [bss_pkg::STATUS_W-1:0]         m_status
);
    import bss_pkg::*;

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = 2 * SAMPLE_BITS + CW;

    typedef enum logic [3:0] {
        ST_ACC    = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        PH_NE   = 4'd0,
        PH_SS   = 4'd1,
        PH_NUM  = 4'd2,
        PH_DEN  = 4'd3,
        PH_VAR  = 4'd4,
        PH_MEAN = 4'd5,
        PH_POW  = 4'd6,
        PH_STD  = 4'd7,
        PH_RMS  = 4'd8
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // accumulators
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic signed [SW-1:0]         sum_reg, sum_next;
    logic [QW-1:0]                sq_reg, sq_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic                         drop_reg, drop_next;

    // block-end working registers
    logic [DP_W-1:0] prod_reg, prod_next;
    logic [DP_W-1:0] den_reg, den_next;
    logic [DP_W-1:0] var_reg, var_next;
    logic [DP_W-1:0] mean_reg, mean_next;
    logic [DP_W-1:0] pow_reg, pow_next;
    logic [DP_W-1:0] std_reg, std_next;
    logic [DP_W-1:0] rms_reg, rms_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [CW-1:0]                 o_cnt_reg;
    logic [MEAN_W-1:0]             o_mean_reg;
    logic [VAR_W-1:0]              o_var_reg;
    logic [STD_W-1:0]              o_std_reg;
    logic [ENERGY_W-1:0]           o_energy_reg;
    logic [POWER_W-1:0]            o_pow_reg;
    logic [RMS_W-1:0]              o_rms_reg;
    logic signed [SAMPLE_BITS-1:0] o_min_reg, o_max_reg;
    logic [STATUS_W-1:0]           o_status_reg;

    logic                           s_acc, out_free, out_load, room;
    logic signed [2*SAMPLE_BITS-1:0] x_sq;
    logic [SW-1:0]                  sum_abs;
    logic [DP_W-1:0]                sum_abs_w, cnt_w, sq_w;
    logic [STATUS_W-1:0]            status_val;

    unit_cmd_t       cmd;
    logic [DP_W-1:0] opnd_a, opnd_b, unit_res, unit_rem;
    logic            unit_done;

    assign s_ready  = (state_reg == ST_ACC);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_FINISH) && out_free;
    assign room     = (cnt_reg < CW'(MAX_COUNT));

    // widened views of the accumulators
    assign x_sq      = s_sample * s_sample;
    assign sum_abs   = sum_reg[SW-1] ? -sum_reg : sum_reg;
    assign sum_abs_w = DP_W'(sum_abs);
    assign cnt_w     = DP_W'(cnt_reg);
    assign sq_w      = DP_W'(sq_reg);

    // sample accumulation, cleared once the result is handed over
    always_comb begin
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        drop_next = drop_reg;
        if (s_acc) begin
            if (!room) begin
                drop_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + CW'(1);
                sum_next = sum_reg + SW'(s_sample);
                sq_next  = sq_reg + QW'($unsigned(x_sq));
                if (cnt_reg == '0 || s_sample < min_reg) begin
                    min_next = s_sample;
                end
                if (cnt_reg == '0 || s_sample > max_reg) begin
                    max_next = s_sample;
                end
            end
        end else if (out_load) begin
            cnt_next  = '0;
            sum_next  = '0;
            sq_next   = '0;
            drop_next = 1'b0;
        end
    end

    // operands for each block-end step
    always_comb begin
        cmd.start = (state_reg == ST_LOAD);
        cmd.kind  = OP_MUL;
        opnd_a    = '0;
        opnd_b    = '0;
        unique case (phase_reg)
            PH_NE: begin
                opnd_a = sq_w;
                opnd_b = cnt_w;
            end
            PH_SS: begin
                opnd_a = sum_abs_w;
                opnd_b = sum_abs_w;
            end
            PH_NUM: begin
                cmd.kind = OP_SUB;
                opnd_a   = prod_reg;
                opnd_b   = var_reg;
            end
            PH_DEN: begin
                opnd_a = cnt_w;
                opnd_b = cnt_w - DP_W'(1);
            end
            PH_VAR: begin
                cmd.kind = OP_DIV;
                opnd_a   = {prod_reg[DP_W-9:0], 8'd0};
                opnd_b   = den_reg;
            end
            PH_MEAN: begin
                cmd.kind = OP_DIV;
                opnd_a   = {sum_abs_w[DP_W-9:0], 8'd0};
                opnd_b   = cnt_w;
            end
            PH_POW: begin
                cmd.kind = OP_DIV;
                opnd_a   = {sq_w[DP_W-9:0], 8'd0};
                opnd_b   = cnt_w;
            end
            PH_STD: begin
                cmd.kind = OP_SQRT;
                opnd_a   = {var_reg[DP_W-9:0], 8'd0};
            end
            PH_RMS: begin
                cmd.kind = OP_SQRT;
                opnd_a   = {pow_reg[DP_W-9:0], 8'd0};
            end
            default: begin
                cmd.kind = OP_MUL;
            end
        endcase
    end

    bss_unit u_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .opnd_a    (opnd_a),
        .opnd_b    (opnd_b),
        .done      (unit_done),
        .result    (unit_res),
        .remainder (unit_rem)
    );

    // sequencer and result capture
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        var_next   = var_reg;
        mean_next  = mean_reg;
        pow_next   = pow_reg;
        std_next   = std_reg;
        rms_next   = rms_reg;
        unique case (state_reg)
            ST_ACC: begin
                if (s_acc && s_last) begin
                    state_next = ST_LOAD;
                    phase_next = PH_NE;
                end
            end
            ST_LOAD: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (unit_done) begin
                    unique case (phase_reg)
                        PH_NE:   prod_next = unit_res;
                        PH_SS:   var_next  = unit_res;
                        PH_NUM:  prod_next = unit_res;
                        PH_DEN:  den_next  = unit_res;
                        PH_VAR:  var_next  = (cnt_reg < CW'(2)) ? '0 : unit_res;
                        PH_MEAN: begin
                            if (sum_reg[SW-1]) begin
                                mean_next = (unit_rem != '0) ? ~unit_res
                                                             : ~unit_res + DP_W'(1);
                            end else begin
                                mean_next = unit_res;
                            end
                        end
                        PH_POW:  pow_next  = unit_res;
                        PH_STD:  std_next  = unit_res;
                        PH_RMS:  rms_next  = unit_res;
                        default: prod_next = prod_reg;
                    endcase
                    if (phase_reg == PH_RMS) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_LOAD;
                        phase_next = phase_t'(phase_reg + 4'd1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    // status of the closed block
    always_comb begin
        priority if (drop_reg) begin
            status_val = ST_DROP;
        end else if (cnt_reg <= CW'(1)) begin
            status_val = ST_SINGLE;
        end else begin
            status_val = ST_OK;
        end
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            phase_reg   <= PH_NE;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        min_reg  <= min_next;
        max_reg  <= max_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        var_reg  <= var_next;
        mean_reg <= mean_next;
        pow_reg  <= pow_next;
        std_reg  <= std_next;
        rms_reg  <= rms_next;
        if (out_load) begin
            o_cnt_reg    <= cnt_reg;
            o_mean_reg   <= mean_reg[MEAN_W-1:0];
            o_var_reg    <= var_reg[VAR_W-1:0];
            o_std_reg    <= std_reg[STD_W-1:0];
            o_energy_reg <= sq_w[ENERGY_W-1:0];
            o_pow_reg    <= pow_reg[POWER_W-1:0];
            o_rms_reg    <= rms_reg[RMS_W-1:0];
            o_min_reg    <= min_reg;
            o_max_reg    <= max_reg;
            o_status_reg <= status_val;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_total = o_cnt_reg;
    assign m_mean_q8      = o_mean_reg;
    assign m_variance_q8  = o_var_reg;
    assign m_std_q8       = o_std_reg;
    assign m_energy       = o_energy_reg;
    assign m_power_q8     = o_pow_reg;
    assign m_rms_q8       = o_rms_reg;
    assign m_minimum      = o_min_reg;
    assign m_maximum      = o_max_reg;
    assign m_status       = o_status_reg;

endmodule

// File: sv/bss_checker.sv
// port-level checks for block_signal_statistics, attached by bind
// depends on bss_pkg
module bss_checker #(
    parameter int MAX_COUNT   = bss_pkg::MAX_COUNT_DEF,
    parameter int SAMPLE_BITS = bss_pkg::SAMPLE_BITS_DEF
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic signed [SAMPLE_BITS-1:0]        s_sample,
    input logic                                 s_last,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [$clog2(MAX_COUNT+1)-1:0]       m_sample_total,
    input logic signed [bss_pkg::MEAN_W-1:0]    m_mean_q8,
    input logic [bss_pkg::VAR_W-1:0]            m_variance_q8,
    input logic [bss_pkg::STD_W-1:0]            m_std_q8,
    input logic [bss_pkg::ENERGY_W-1:0]         m_energy,
    input logic [bss_pkg::POWER_W-1:0]          m_power_q8,
    input logic [bss_pkg::RMS_W-1:0]            m_rms_q8,
    input logic signed [SAMPLE_BITS-1:0]        m_minimum,
    input logic signed [SAMPLE_BITS-1:0]        m_maximum,
    input logic [bss_pkg::STATUS_W-1:0]         m_status
);
    import bss_pkg::*;

    // a closing sample starts the block-end work, so input stalls next cycle
    a_close_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input still ready after closing sample");

    // a single-sample block has no spread
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_SINGLE |->
            m_variance_q8 == '0 && m_std_q8 == '0 && m_sample_total == 1)
        else $error("single-sample word with non-zero spread");

    // extremes are ordered
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_minimum <= m_maximum)
        else $error("minimum above maximum");

    // a waiting word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_q8) && $stable(m_energy)
            && $stable(m_power_q8) && $stable(m_rms_q8))
        else $error("result word changed while stalled");

endmodule

bind block_signal_statistics bss_checker #(
    .MAX_COUNT   (MAX_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bss_checker (.*);
